@@ rtl/core/mhvc_pkg.sv @@
// Package with register map codes, field widths and reset values of the valve controller.
`timescale 1ns / 1ps

package mhvc_pkg;

  // Payload and register widths.
  localparam int unsigned SampleW  = 10;
  localparam int unsigned StoreW   = 11;
  localparam int unsigned CountW   = 8;
  localparam int unsigned OffsetW  = 6;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [RegIdxW-1:0] REG_DRY_LEVEL    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DAMP_LEVEL   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_FAULT_LIMIT  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_VALID_LOW    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_VALID_HIGH   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_FIRST_OFFSET = 3'd5;

  // Register reset values.
  localparam logic [SampleW-1:0] DRY_LEVEL_RST    = 10'd455;
  localparam logic [SampleW-1:0] DAMP_LEVEL_RST   = 10'd345;
  localparam logic [CountW-1:0]  FAULT_LIMIT_RST  = 8'd3;
  localparam logic [SampleW-1:0] VALID_LOW_RST    = 10'd280;
  localparam logic [SampleW-1:0] VALID_HIGH_RST   = 10'd620;
  localparam logic [OffsetW-1:0] FIRST_OFFSET_RST = 6'd20;

  // Saturation bound of the failure counter.
  localparam logic [CountW-1:0]  COUNT_MAX        = 8'd255;

endpackage

@@ rtl/core/moisture_hysteresis_valve_control.sv @@
// Top level of the moisture hysteresis valve controller.
`timescale 1ns / 1ps

// Usage:
// One raw converter sample enters per transfer on the input channel (in_valid_i,
// in_stall_o, adc_sample_i); the sensors are visited round robin, starting at sensor 1
// after reset. Each sample produces exactly one result transfer on the output channel
// (out_valid_o, out_stall_i) carrying the valve drive, the fault flag, the moisture
// average and the failure count.
// The transfer edge captures a sample in the input register, and the edge at which it
// advances writes the state and the result register. Throughput is one sample per cycle
// while the receiver does not stall, since the input register can take a new sample at
// the same edge at which its current one moves into the result register. When the
// receiver stalls, the result register holds its transfer and the input register can
// still take one more sample before in_stall_o rises.
// Reset clears the sample store, the average, the failure counter and the valve (closed),
// and loads the default levels and window. Configuration registers sit on the APB port
// at byte address 4*i; the user writes them only while the block is idle (unenforced).
module moisture_hysteresis_valve_control #(
  parameter int unsigned SENSORS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mhvc_pkg::SampleW-1:0]  adc_sample_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          valve_open_o,
  output logic                          fault_o,
  output logic [mhvc_pkg::SampleW-1:0]  moisture_average_o,
  output logic [mhvc_pkg::CountW-1:0]   failure_count_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mhvc_pkg::AddrW-1:0]    paddr,
  input  logic [mhvc_pkg::DataW-1:0]    pwdata,
  output logic [mhvc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned IdxW    = $clog2(SENSORS);
  localparam int unsigned SumW    = mhvc_pkg::StoreW + $clog2(SENSORS);
  localparam int unsigned Shift   = SumW + $clog2(SENSORS);
  localparam int unsigned Recip   = ((2 ** Shift) + SENSORS - 1) / SENSORS;
  localparam int unsigned RecipW  = Shift + 1;
  localparam int unsigned ProdW   = SumW + RecipW;

  // Configuration registers.
  logic [mhvc_pkg::SampleW-1:0] dry_level_q;
  logic [mhvc_pkg::SampleW-1:0] damp_level_q;
  logic [mhvc_pkg::CountW-1:0]  fault_limit_q;
  logic [mhvc_pkg::SampleW-1:0] valid_low_q;
  logic [mhvc_pkg::SampleW-1:0] valid_high_q;
  logic [mhvc_pkg::OffsetW-1:0] first_offset_q;

  logic                         cfg_wr;
  logic [mhvc_pkg::RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[mhvc_pkg::AddrW-1:2];

  // Register writes complete in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_level_q    <= mhvc_pkg::DRY_LEVEL_RST;
      damp_level_q   <= mhvc_pkg::DAMP_LEVEL_RST;
      fault_limit_q  <= mhvc_pkg::FAULT_LIMIT_RST;
      valid_low_q    <= mhvc_pkg::VALID_LOW_RST;
      valid_high_q   <= mhvc_pkg::VALID_HIGH_RST;
      first_offset_q <= mhvc_pkg::FIRST_OFFSET_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mhvc_pkg::REG_DRY_LEVEL:    dry_level_q    <= pwdata[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_DAMP_LEVEL:   damp_level_q   <= pwdata[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_FAULT_LIMIT:  fault_limit_q  <= pwdata[mhvc_pkg::CountW-1:0];
        mhvc_pkg::REG_VALID_LOW:    valid_low_q    <= pwdata[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_VALID_HIGH:   valid_high_q   <= pwdata[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_FIRST_OFFSET: first_offset_q <= pwdata[mhvc_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      mhvc_pkg::REG_DRY_LEVEL:    prdata = mhvc_pkg::DataW'(dry_level_q);
      mhvc_pkg::REG_DAMP_LEVEL:   prdata = mhvc_pkg::DataW'(damp_level_q);
      mhvc_pkg::REG_FAULT_LIMIT:  prdata = mhvc_pkg::DataW'(fault_limit_q);
      mhvc_pkg::REG_VALID_LOW:    prdata = mhvc_pkg::DataW'(valid_low_q);
      mhvc_pkg::REG_VALID_HIGH:   prdata = mhvc_pkg::DataW'(valid_high_q);
      mhvc_pkg::REG_FIRST_OFFSET: prdata = mhvc_pkg::DataW'(first_offset_q);
      default:                    prdata = '0;
    endcase
  end

  // Pipeline handshake: input register feeds the result register.
  logic                         in_valid_q;
  logic [mhvc_pkg::SampleW-1:0] sample_q;
  logic                         out_valid_q;
  logic                         advance;
  logic                         accept;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= adc_sample_i;
    end
  end

  // Controller state.
  logic [IdxW-1:0]               sensor_idx_q;
  logic [mhvc_pkg::StoreW-1:0]   store_q [SENSORS];
  logic [mhvc_pkg::SampleW-1:0]  average_q;
  logic [mhvc_pkg::CountW-1:0]   fail_cnt_q;
  logic                          valve_q;

  logic [IdxW-1:0]               idx_eff;
  logic                          idx_zero;
  logic [IdxW-1:0]               sensor_idx_d;
  logic [SumW-1:0]               win_sum;
  logic [ProdW-1:0]              prod;
  logic [SumW-1:0]               quot_est;
  logic [SumW-1:0]               quot_rem;
  logic [SumW-1:0]               quot;
  logic [mhvc_pkg::SampleW-1:0]  average_d;
  logic [mhvc_pkg::StoreW-1:0]   stored_val;
  logic                          in_window;
  logic [mhvc_pkg::CountW-1:0]   fail_cnt_d;
  logic                          fault_d;
  logic                          valve_set;
  logic                          valve_d;

  // Index selection; an out-of-range index counts as sensor zero.
  always_comb begin
    idx_eff  = (32'(sensor_idx_q) >= SENSORS) ? '0 : sensor_idx_q;
    idx_zero = (idx_eff == '0);
    if (32'(idx_eff) + 32'd1 >= SENSORS) begin
      sensor_idx_d = '0;
    end else begin
      sensor_idx_d = idx_eff + IdxW'(1);
    end
  end

  // Sum of stored entries strictly inside the plausibility window.
  always_comb begin
    win_sum = '0;
    for (int k = 0; k < SENSORS; k++) begin
      if ((store_q[k] > mhvc_pkg::StoreW'(valid_low_q)) &&
          (store_q[k] < mhvc_pkg::StoreW'(valid_high_q))) begin
        win_sum = win_sum + SumW'(store_q[k]);
      end
    end
  end

  // Divide by the sensor count with a reciprocal multiply and one correction step.
  always_comb begin
    prod     = ProdW'(win_sum) * ProdW'(RecipW'(Recip));
    quot_est = prod[Shift +: SumW];
    quot_rem = win_sum - SumW'(quot_est * SumW'(SENSORS));
    quot     = (quot_rem >= SumW'(SENSORS)) ? quot_est + SumW'(1) : quot_est;
    average_d = idx_zero ? quot[mhvc_pkg::SampleW-1:0] : average_q;
  end

  // Calibrated value for the store; sensor zero carries the offset.
  assign stored_val = idx_zero
                    ? mhvc_pkg::StoreW'(sample_q) + mhvc_pkg::StoreW'(first_offset_q)
                    : mhvc_pkg::StoreW'(sample_q);

  // Failure counter and hysteresis.
  always_comb begin
    in_window = (sample_q >= valid_low_q) && (sample_q <= valid_high_q);
    if (!in_window) begin
      fail_cnt_d = (fail_cnt_q != mhvc_pkg::COUNT_MAX) ? fail_cnt_q + 8'd1 : fail_cnt_q;
    end else begin
      fail_cnt_d = (fail_cnt_q != '0) ? fail_cnt_q - 8'd1 : fail_cnt_q;
    end
    fault_d   = fail_cnt_d > fault_limit_q;
    valve_set = valve_q | (average_d > dry_level_q);
    if (fault_d) begin
      valve_d = 1'b0;
    end else begin
      valve_d = valve_set & ~(average_d < damp_level_q);
    end
  end

  // State update at each transfer into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_idx_q <= IdxW'(1);
      for (int k = 0; k < SENSORS; k++) begin
        store_q[k] <= '0;
      end
      average_q  <= '0;
      fail_cnt_q <= '0;
      valve_q    <= 1'b0;
    end else if (advance) begin
      sensor_idx_q     <= sensor_idx_d;
      store_q[idx_eff] <= stored_val;
      average_q        <= average_d;
      fail_cnt_q       <= fail_cnt_d;
      valve_q          <= valve_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic                         res_valve_q;
  logic                         res_fault_q;
  logic [mhvc_pkg::SampleW-1:0] res_average_q;
  logic [mhvc_pkg::CountW-1:0]  res_count_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_valve_q   <= valve_d;
      res_fault_q   <= fault_d;
      res_average_q <= average_d;
      res_count_q   <= fail_cnt_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign valve_open_o       = res_valve_q;
  assign fault_o            = res_fault_q;
  assign moisture_average_o = res_average_q;
  assign failure_count_o    = res_count_q;

endmodule

@@ sim/tb_moisture_hysteresis_valve_control.sv @@
// Self-checking testbench for the moisture hysteresis valve controller.
`timescale 1ns / 1ps

module tb_moisture_hysteresis_valve_control;

  localparam int unsigned SENSORS      = 2;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SHOWN_ERRORS = 40;

  // One result transfer as it leaves the block.
  typedef struct packed {
    logic                          valve_open;
    logic                          fault;
    logic [mhvc_pkg::SampleW-1:0]  moisture_average;
    logic [mhvc_pkg::CountW-1:0]   failure_count;
  } valve_report_t;

  // Scoreboard: mirrors the controller state and holds the pending valve reports.
  class valve_scoreboard;
    logic [mhvc_pkg::SampleW-1:0] dry_level;
    logic [mhvc_pkg::SampleW-1:0] damp_level;
    logic [mhvc_pkg::CountW-1:0]  fault_limit;
    logic [mhvc_pkg::SampleW-1:0] valid_low;
    logic [mhvc_pkg::SampleW-1:0] valid_high;
    logic [mhvc_pkg::OffsetW-1:0] first_offset;

    int unsigned                  sensor_sel;
    logic [mhvc_pkg::StoreW-1:0]  calibrated[SENSORS];
    logic [mhvc_pkg::SampleW-1:0] average;
    logic [mhvc_pkg::CountW-1:0]  fail_count;
    logic                         valve;

    valve_report_t      pending_reports[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        faults_seen;
    int unsigned        opens_seen;

    function new();
      dry_level    = mhvc_pkg::DRY_LEVEL_RST;
      damp_level   = mhvc_pkg::DAMP_LEVEL_RST;
      fault_limit  = mhvc_pkg::FAULT_LIMIT_RST;
      valid_low    = mhvc_pkg::VALID_LOW_RST;
      valid_high   = mhvc_pkg::VALID_HIGH_RST;
      first_offset = mhvc_pkg::FIRST_OFFSET_RST;
      sensor_sel   = 1;
      foreach (calibrated[k]) calibrated[k] = '0;
      average      = '0;
      fail_count   = '0;
      valve        = 1'b0;
      errors       = 0;
      checked      = 0;
      faults_seen  = 0;
      opens_seen   = 0;
    endfunction

    function void set_register(logic [mhvc_pkg::RegIdxW-1:0] idx,
                               logic [mhvc_pkg::DataW-1:0] value);
      case (idx)
        mhvc_pkg::REG_DRY_LEVEL:    dry_level    = value[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_DAMP_LEVEL:   damp_level   = value[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_FAULT_LIMIT:  fault_limit  = value[mhvc_pkg::CountW-1:0];
        mhvc_pkg::REG_VALID_LOW:    valid_low    = value[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_VALID_HIGH:   valid_high   = value[mhvc_pkg::SampleW-1:0];
        mhvc_pkg::REG_FIRST_OFFSET: first_offset = value[mhvc_pkg::OffsetW-1:0];
        default: ;
      endcase
    endfunction

    function logic [mhvc_pkg::DataW-1:0] register_value(logic [mhvc_pkg::RegIdxW-1:0] idx);
      case (idx)
        mhvc_pkg::REG_DRY_LEVEL:    return mhvc_pkg::DataW'(dry_level);
        mhvc_pkg::REG_DAMP_LEVEL:   return mhvc_pkg::DataW'(damp_level);
        mhvc_pkg::REG_FAULT_LIMIT:  return mhvc_pkg::DataW'(fault_limit);
        mhvc_pkg::REG_VALID_LOW:    return mhvc_pkg::DataW'(valid_low);
        mhvc_pkg::REG_VALID_HIGH:   return mhvc_pkg::DataW'(valid_high);
        mhvc_pkg::REG_FIRST_OFFSET: return mhvc_pkg::DataW'(first_offset);
        default:                    return '0;
      endcase
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    // Advances the controller by one accepted sample and queues the report it must give.
    function void note_sample(logic [mhvc_pkg::SampleW-1:0] sample);
      int unsigned   sel;
      int unsigned   total;
      logic          faulted;
      valve_report_t rep;
      sel = (sensor_sel >= SENSORS) ? 0 : sensor_sel;

      // The average is refreshed from the old store before sensor zero is overwritten.
      if (sel == 0) begin
        total = 0;
        foreach (calibrated[k]) begin
          if (calibrated[k] > mhvc_pkg::StoreW'(valid_low) &&
              calibrated[k] < mhvc_pkg::StoreW'(valid_high))
            total += calibrated[k];
        end
        average = mhvc_pkg::SampleW'(total / SENSORS);
      end
      calibrated[sel] = (sel == 0)
                      ? mhvc_pkg::StoreW'(sample) + mhvc_pkg::StoreW'(first_offset)
                      : mhvc_pkg::StoreW'(sample);
      sensor_sel = (sel + 1 >= SENSORS) ? 0 : sel + 1;

      // The raw sample moves the saturating failure count.
      if (sample < valid_low || sample > valid_high) begin
        if (fail_count != mhvc_pkg::COUNT_MAX) fail_count++;
      end else if (fail_count != '0) begin
        fail_count--;
      end

      // A fault forces the valve closed; otherwise open is tested before close.
      faulted = fail_count > fault_limit;
      if (faulted) begin
        valve = 1'b0;
      end else begin
        if (average > dry_level && !valve) valve = 1'b1;
        if (valve && average < damp_level) valve = 1'b0;
      end

      rep.valve_open       = valve;
      rep.fault            = faulted;
      rep.moisture_average = average;
      rep.failure_count    = fail_count;
      pending_reports.push_back(rep);
    endfunction

    task report_mismatch(string what, int got, int want);
      if (errors < SHOWN_ERRORS)
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    // Compares one result transfer with the oldest pending report.
    task check_result(valve_report_t got);
      valve_report_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch("result transfer with nothing pending", pending_reports.size(), 1);
      end else begin
        want = pending_reports.pop_front();
        checked++;
        if (want.fault) faults_seen++;
        if (want.valve_open) opens_seen++;
        if (got.valve_open !== want.valve_open)
          report_mismatch("valve_open", got.valve_open, want.valve_open);
        if (got.fault !== want.fault)
          report_mismatch("fault", got.fault, want.fault);
        if (got.moisture_average !== want.moisture_average)
          report_mismatch("moisture_average", got.moisture_average, want.moisture_average);
        if (got.failure_count !== want.failure_count)
          report_mismatch("failure_count", got.failure_count, want.failure_count);
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [mhvc_pkg::SampleW-1:0]  adc_sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          valve_open_o;
  logic                          fault_o;
  logic [mhvc_pkg::SampleW-1:0]  moisture_average_o;
  logic [mhvc_pkg::CountW-1:0]   failure_count_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mhvc_pkg::AddrW-1:0]    paddr;
  logic [mhvc_pkg::DataW-1:0]    pwdata;
  logic [mhvc_pkg::DataW-1:0]    prdata;
  logic                          pready;

  valve_scoreboard    sb = new();
  int                 drift_level;
  int unsigned        settings_applied;

  moisture_hysteresis_valve_control #(
    .SENSORS(SENSORS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_sample_i       (adc_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .valve_open_o       (valve_open_o),
    .fault_o            (fault_o),
    .moisture_average_o (moisture_average_o),
    .failure_count_o    (failure_count_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("moisture_hysteresis_valve_control test failed");
    $finish;
  end

  // The receiver stalls on a pattern whose mode is redrawn at random from four modes.
  initial begin : result_stall
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 2) == 0);
        2:       out_stall_i <= ((cyc % 8) >= 5);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
      cyc++;
    end
  end

  // Every result transfer is checked against the scoreboard.
  initial begin : result_monitor
    valve_report_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.valve_open       = valve_open_o;
        got.fault            = fault_o;
        got.moisture_average = moisture_average_o;
        got.failure_count    = failure_count_o;
        sb.check_result(got);
      end
    end
  end

  // Offers one sample at a falling edge and holds it until the transfer.
  // Returns at the falling edge after the transfer without driving anything there.
  task automatic send_sample(input logic [mhvc_pkg::SampleW-1:0] sample);
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(sample);
    @(negedge clk_i);
  endtask

  // One register access on the configuration port, setup then access cycle.
  task automatic apb_access(input logic write, input logic [mhvc_pkg::RegIdxW-1:0] idx,
                            input logic [mhvc_pkg::DataW-1:0] wdata,
                            output logic [mhvc_pkg::DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every pending report has come out and the pipeline is empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Loads a full register setting while the block is idle and reads it back.
  task automatic apply_setting(input int dry, input int damp, input int limit,
                               input int vlow, input int vhigh, input int offs);
    logic [mhvc_pkg::DataW-1:0] values[6];
    logic [mhvc_pkg::DataW-1:0] rd;
    values = '{mhvc_pkg::DataW'(dry), mhvc_pkg::DataW'(damp), mhvc_pkg::DataW'(limit),
               mhvc_pkg::DataW'(vlow), mhvc_pkg::DataW'(vhigh), mhvc_pkg::DataW'(offs)};
    drain_results();
    for (int i = 0; i < 6; i++) begin
      apb_access(1'b1, mhvc_pkg::RegIdxW'(i), values[i], rd);
      sb.set_register(mhvc_pkg::RegIdxW'(i), values[i]);
    end
    for (int i = 0; i < 6; i++) begin
      apb_access(1'b0, mhvc_pkg::RegIdxW'(i), '0, rd);
      if (rd !== sb.register_value(mhvc_pkg::RegIdxW'(i)))
        sb.report_mismatch($sformatf("readback of register %0d", i),
                           int'(rd), int'(sb.register_value(mhvc_pkg::RegIdxW'(i))));
    end
    settings_applied++;
    @(negedge clk_i);
  endtask

  // Mostly samples around a drifting moisture level, with window edges and noise.
  function automatic logic [mhvc_pkg::SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = int'($urandom_range(0, 1023));
      1:       v = int'(sb.valid_low) - 1 + int'($urandom_range(0, 2));
      2:       v = int'(sb.valid_high) - 1 + int'($urandom_range(0, 2));
      default: v = drift_level + int'($urandom_range(0, 40)) - 20;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return mhvc_pkg::SampleW'(v);
  endfunction

  // Random traffic in bursts with gaps, now and then pausing until all reports are out.
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 11) == 0) begin
          if (sb.valid_low <= sb.valid_high)
            drift_level = int'($urandom_range(sb.valid_low, sb.valid_high));
          else
            drift_level = int'($urandom_range(0, 1023));
        end
        send_sample(pick_sample());
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        drain_results();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
  endtask

  // Main sequence: reset, directed samples, then settings with random traffic.
  initial begin : stimulus
    logic [mhvc_pkg::SampleW-1:0] directed[$];
    int                 vlow;
    int                 vhigh;
    int                 damp;
    int                 dry;
    int unsigned        waited;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    adc_sample_i    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    drift_level     = 400;
    settings_applied = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part at reset levels: field extremes, inclusive window edges, a store
    // value exactly on the low bound, offset pushing sensor zero past the high bound,
    // a fault burst and its recovery, then the valve opening and closing.
    directed = '{10'd1023, 10'd0, 10'd280, 10'd620, 10'd279, 10'd621, 10'd1023, 10'd1023,
                 10'd610, 10'd590, 10'd590, 10'd590, 10'd590, 10'd590, 10'd590, 10'd590,
                 10'd590, 10'd300, 10'd300, 10'd300, 10'd300, 10'd260, 10'd300, 10'd300};
    foreach (directed[i]) send_sample(directed[i]);
    run_random(180);

    // Widest window, largest offset, levels at opposite extremes.
    apply_setting(1023, 0, 255, 0, 1023, 63);
    run_random(180);

    // Crossed levels: the valve may open and close within one sample; no fault margin.
    apply_setting(0, 1023, 0, 100, 900, 0);
    run_random(180);

    // Inverted window: every sample misses, so the failure count saturates.
    apply_setting(500, 400, 255, 1023, 0, 31);
    run_random(300);

    // Random but sensible settings.
    for (int p = 0; p < 5; p++) begin
      vlow  = int'($urandom_range(150, 450));
      vhigh = int'($urandom_range(vlow + 50, 900));
      damp  = int'($urandom_range(vlow, vhigh));
      dry   = int'($urandom_range(damp, vhigh));
      apply_setting(dry, damp, int'($urandom_range(0, 12)), vlow, vhigh,
                    int'($urandom_range(0, 63)));
      run_random(140);
    end

    // Let the last reports come out, within a limit.
    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.pending() != 0)
      sb.report_mismatch("reports never delivered", 0, int'(sb.pending()));
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d result transfers over %0d register settings.",
             sb.checked, settings_applied + 1);
    $display("Reports with the valve open: %0d, with the fault flag: %0d, mismatches: %0d.",
             sb.opens_seen, sb.faults_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("moisture_hysteresis_valve_control test passed");
    end else begin
      $display("moisture_hysteresis_valve_control test failed");
    end
    $finish;
  end

endmodule
